[rtl/assert_macros.svh]
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLY(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error(msg);

`endif

[rtl/ipfnb_pkg.sv]
package ipfnb_pkg;

	localparam int CFG_W = 10;
	localparam int POS_W = 2 * CFG_W;
	localparam int PIX_W = 8;
	localparam int IDX_W = 18;
	localparam int MAX_WIDTH_DEF = 512;
	localparam int MAX_HEIGHT_DEF = 512;
	localparam int MIN_WIDTH = 2;
	localparam int MIN_HEIGHT = 3;
	localparam logic [CFG_W-1:0] WIDTH_RST = 10'd320;
	localparam logic [CFG_W-1:0] HEIGHT_RST = 10'd200;
	localparam logic [POS_W-1:0] TOTAL_RST = 20'd64000;

	typedef enum logic [0:0] {
		REG_FRAME_WIDTH = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_RUN = 4'b0001,
		ST_WAIT = 4'b0010,
		ST_LOAD = 4'b0100,
		ST_DIV = 4'b1000
	} pos_state_t;

	typedef struct packed {
		logic has_first;
		logic blur;
		logic has_second;
		logic frame_end;
	} s1_info_t;

	function automatic logic [CFG_W-1:0] clamp_cfg(input logic [CFG_W-1:0] v, input int lo,
			input int hi);
		logic [CFG_W-1:0] r;
		r = v;
		if (int'(v) < lo) r = CFG_W'(lo);
		else if (int'(v) > hi) r = CFG_W'(hi);
		return r;
	endfunction

endpackage

[rtl/in_place_four_neighbour_blur_core.sv]
// Streaming four-neighbour blur that behaves as an in-place raster-order blur of one frame.
// Pixels enter one per clock while in_ready is high. Each input from the second row on
// yields the blurred pixel one row above it, and each input of the last row also yields a
// zero for its own position. First-row inputs yield nothing, last-row inputs yield two
// results and all others one. A result passes stage 1 and then an output slot.
// Two row memories of MAX_WIDTH bytes, each with one read and one write port, hold the
// previous row of original and blurred pixels. After a write of frame_width or frame_height
// the block holds off input through a wait state, a load state and 20 steps of a bit-serial
// divider that derives row and column from the kept frame position. If the kept position
// lies outside the new frame, the load state restarts the position at zero instead.
module in_place_four_neighbour_blur_core #(
	parameter int MAX_WIDTH = ipfnb_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = ipfnb_pkg::MAX_HEIGHT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  ipfnb_pkg::reg_idx_t           cfg_index,
	input  logic [ipfnb_pkg::CFG_W-1:0]   cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [ipfnb_pkg::PIX_W-1:0]   old_pixel,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ipfnb_pkg::IDX_W-1:0]   pixel_index,
	output logic [ipfnb_pkg::PIX_W-1:0]   new_pixel,
	output logic                          frame_done
);
	import ipfnb_pkg::*;
	`include "assert_macros.svh"

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int CNT_W = $clog2(POS_W + 1);

	// geometry
	logic [CFG_W-1:0] w_q, h_q;
	logic [POS_W-1:0] total_q;

	// frame position
	logic [CFG_W-1:0] col_q, row_q;
	logic [POS_W-1:0] pos_q;
	pos_state_t state_q;

	// divider
	logic [CFG_W-1:0] rem_q;
	logic [POS_W-1:0] dvd_q, quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CFG_W:0] rem_sh;
	logic rem_ge;
	logic [CFG_W-1:0] rem_nx;
	logic [POS_W-1:0] quo_nx;

	// row memories
	logic [PIX_W-1:0] old_row_q [MAX_WIDTH];
	logic [PIX_W-1:0] new_row_q [MAX_WIDTH];

	// stage 1
	logic s1_v_q;
	s1_info_t info_s1;
	logic [PIX_W-1:0] pix_s1, old_rd_s1, new_rd_s1;
	logic [CFG_W-1:0] col_s1;
	logic [POS_W-1:0] pos_s1, up_s1;
	logic [PIX_W-1:0] last_new_q;

	// output slots
	logic va_q, vb_q;
	logic [IDX_W-1:0] a_idx_q, b_idx_q;
	logic [PIX_W-1:0] a_pix_q;
	logic b_done_q;

	logic in_xfer, out_xfer, out_free, s1_go;
	logic col_last, row_last;
	logic [CFG_W-1:0] right_col;
	logic [PIX_W+1:0] sum;
	logic [PIX_W-1:0] val;

	// handshake
	assign out_valid = va_q | vb_q;
	assign out_xfer = out_valid & out_ready;
	assign out_free = (~va_q & ~vb_q) | (out_ready & (va_q ^ vb_q));
	assign s1_go = s1_v_q & out_free;
	assign in_ready = (state_q == ST_RUN) & (~s1_v_q | s1_go);
	assign in_xfer = in_valid & in_ready;

	// position decode
	assign col_last = (col_q == w_q - 1'b1);
	assign row_last = (row_q == h_q - 1'b1);
	assign right_col = col_last ? '0 : col_q + 1'b1;

	// blur arithmetic
	assign sum = {2'b00, last_new_q} + {2'b00, old_rd_s1} + {2'b00, new_rd_s1}
		+ {2'b00, pix_s1};
	assign val = info_s1.blur ? sum[PIX_W+1:2] : '0;

	// one restoring divider step
	assign rem_sh = {rem_q, dvd_q[POS_W-1]};
	assign rem_ge = (rem_sh >= {1'b0, w_q});
	assign rem_nx = rem_ge ? CFG_W'(rem_sh - {1'b0, w_q}) : rem_sh[CFG_W-1:0];
	assign quo_nx = {quo_q[POS_W-2:0], rem_ge};

	// result mux
	assign pixel_index = va_q ? a_idx_q : b_idx_q;
	assign new_pixel = va_q ? a_pix_q : '0;
	assign frame_done = va_q ? 1'b0 : b_done_q;

	// configuration registers and frame size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= WIDTH_RST;
			h_q <= HEIGHT_RST;
			total_q <= TOTAL_RST;
		end else begin
			total_q <= {{CFG_W{1'b0}}, w_q} * {{CFG_W{1'b0}}, h_q};
			if (cfg_we) begin
				case (cfg_index)
					REG_FRAME_WIDTH: w_q <= clamp_cfg(cfg_data, MIN_WIDTH, MAX_WIDTH);
					REG_FRAME_HEIGHT: h_q <= clamp_cfg(cfg_data, MIN_HEIGHT, MAX_HEIGHT);
					default: ;
				endcase
			end
		end
	end

	// advance position; rederive row and column after a geometry change
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			col_q <= '0;
			row_q <= '0;
			pos_q <= '0;
			rem_q <= '0;
			dvd_q <= '0;
			quo_q <= '0;
			cnt_q <= '0;
		end else if (cfg_we) begin
			state_q <= ST_WAIT;
		end else begin
			case (state_q)
				ST_RUN: begin
					if (in_xfer) begin
						if (col_last) begin
							col_q <= '0;
							if (row_last) begin
								row_q <= '0;
								pos_q <= '0;
							end else begin
								row_q <= row_q + 1'b1;
								pos_q <= pos_q + 1'b1;
							end
						end else begin
							col_q <= col_q + 1'b1;
							pos_q <= pos_q + 1'b1;
						end
					end
				end
				ST_WAIT: state_q <= ST_LOAD;
				ST_LOAD: begin
					if (pos_q >= total_q) begin
						pos_q <= '0;
						col_q <= '0;
						row_q <= '0;
						state_q <= ST_RUN;
					end else begin
						rem_q <= '0;
						quo_q <= '0;
						dvd_q <= pos_q;
						cnt_q <= CNT_W'(POS_W);
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q <= rem_nx;
					quo_q <= quo_nx;
					dvd_q <= {dvd_q[POS_W-2:0], 1'b0};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) begin
						col_q <= rem_nx;
						row_q <= quo_nx[CFG_W-1:0];
						state_q <= ST_RUN;
					end
				end
				default: state_q <= ST_RUN;
			endcase
		end
	end

	// row memories: store the original pixel on transfer, the blurred one on stage exit
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			old_row_q[AW'(col_q)] <= old_pixel;
			old_rd_s1 <= old_row_q[AW'(right_col)];
			new_rd_s1 <= new_row_q[AW'(col_q)];
		end
		if (s1_go && info_s1.has_first) begin
			new_row_q[AW'(col_s1)] <= val;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			pix_s1 <= old_pixel;
			col_s1 <= col_q;
			pos_s1 <= pos_q;
			up_s1 <= pos_q - {{CFG_W{1'b0}}, w_q};
			info_s1.has_first <= (row_q != '0);
			info_s1.blur <= (row_q != '0) && (row_q != CFG_W'(1));
			info_s1.has_second <= row_last;
			info_s1.frame_end <= row_last & col_last;
		end
	end

	// stage 1 valid and last blurred value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
			last_new_q <= '0;
		end else begin
			if (in_xfer) s1_v_q <= 1'b1;
			else if (s1_go) s1_v_q <= 1'b0;
			if (s1_go && info_s1.has_first) last_new_q <= val;
		end
	end

	// output slots: first result, then the last-row zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_q <= 1'b0;
			vb_q <= 1'b0;
		end else if (s1_go) begin
			va_q <= info_s1.has_first;
			vb_q <= info_s1.has_second;
		end else if (out_xfer) begin
			if (va_q) va_q <= 1'b0;
			else vb_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			a_idx_q <= up_s1[IDX_W-1:0];
			a_pix_q <= val;
			b_idx_q <= pos_s1[IDX_W-1:0];
			b_done_q <= info_s1.frame_end;
		end
	end

	`ASSERT_IMPLY(a_no_input_in_resync, state_q != ST_RUN, !in_ready, "input taken during resync")
	`ASSERT_IMPLY(a_col_in_range, state_q == ST_RUN, col_q < w_q, "column beyond frame width")
	`ASSERT_IMPLY(a_row_in_range, state_q == ST_RUN, row_q < h_q, "row beyond frame height")
	`ASSERT_IMPLY(a_done_on_second, out_valid && frame_done, !va_q && vb_q,
		"frame end not on the second result")
	`ASSERT_CLK(a_stage_load_free, !(s1_go && va_q && vb_q), "stage exit into full output slots")

endmodule

[tb/tb_in_place_four_neighbour_blur_core.sv]
module tb_in_place_four_neighbour_blur_core;
	import ipfnb_pkg::*;

	localparam int unsigned MAX_DIM = 512;
	localparam int unsigned LONG_HOLD = 300;
	localparam int unsigned RANDOM_ITEMS = 120;

	// one blurred pixel as it leaves the block
	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [PIX_W-1:0] val;
		logic             done;
	} blur_result_t;

	// one line of the directed stimulus: a register write or a pixel, where a typed pixel
	// carries its results (none, or one zero at zero_idx) instead of asking the blur model
	typedef struct {
		bit                     is_cfg;
		reg_idx_t               reg_sel;
		logic [CFG_W-1:0]       reg_val;
		logic [PIX_W-1:0]       pix;
		bit                     typed;
		int unsigned            n;
		logic [IDX_W-1:0]       zero_idx;
	} dir_row_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	reg_idx_t         cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic             in_valid;
	logic             in_ready;
	logic [PIX_W-1:0] old_pixel;
	logic             out_valid;
	logic             out_ready;
	logic [IDX_W-1:0] pixel_index;
	logic [PIX_W-1:0] new_pixel;
	logic             frame_done;

	// blur model state
	logic [CFG_W-1:0] width_reg = 10'd320;
	logic [CFG_W-1:0] height_reg = 10'd200;
	logic [PIX_W-1:0] old_row [MAX_DIM];
	logic [PIX_W-1:0] new_row [MAX_DIM];
	logic [PIX_W-1:0] prev_blur = '0;
	int unsigned      frame_pos = 0;

	blur_result_t     blur_results_due[$];
	dir_row_t         directed_rows[$];
	dir_row_t         cur_row;
	int unsigned      mismatches = 0;
	int unsigned      rand_items = 0;
	bit               hold_request = 1'b0;

	in_place_four_neighbour_blur_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.old_pixel   (old_pixel),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_index (pixel_index),
		.new_pixel   (new_pixel),
		.frame_done  (frame_done)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned lo);
		if (v < lo) return lo;
		if (v > MAX_DIM) return MAX_DIM;
		return 32'(v);
	endfunction

	// blur one incoming pixel and return the zero, one or two pixels it releases
	function automatic void apply_blur(input logic [PIX_W-1:0] pix, output int unsigned n,
			output blur_result_t res_a, output blur_result_t res_b);
		int unsigned w, h, total, q, col, row, rc, sum;
		logic [PIX_W-1:0] v;
		blur_result_t tail;
		w = clamp_dim(width_reg, 2);
		h = clamp_dim(height_reg, 3);
		total = w * h;
		n = 0;
		res_a = '0;
		res_b = '0;
		if (frame_pos >= total) frame_pos = 0;
		q = frame_pos;
		col = q % w;
		row = q / w;
		rc = (col + 1) % w;
		// release the pixel one row up; row 0 stays zero
		if (row >= 1) begin
			if (row == 1) begin
				v = '0;
			end else begin
				sum = 32'(prev_blur) + 32'(old_row[rc]) + 32'(new_row[col]) + 32'(pix);
				v = PIX_W'(sum >> 2);
			end
			new_row[col] = v;
			prev_blur = v;
			res_a = '{idx: IDX_W'(q - w), val: v, done: 1'b0};
			n = 1;
		end
		old_row[col] = pix;
		// last row zeroes its own position too
		if (row == h - 1) begin
			tail = '{idx: IDX_W'(q), val: '0, done: (q == total - 1)};
			if (n == 0) res_a = tail;
			else res_b = tail;
			n++;
		end
		frame_pos = (q + 1 >= total) ? 0 : q + 1;
	endfunction

	function automatic dir_row_t cfg_row(input reg_idx_t sel, input logic [CFG_W-1:0] val);
		dir_row_t r;
		r.is_cfg = 1'b1;
		r.reg_sel = sel;
		r.reg_val = val;
		r.pix = '0;
		r.typed = 1'b0;
		r.n = 0;
		r.zero_idx = '0;
		return r;
	endfunction

	function automatic dir_row_t px_row(input logic [PIX_W-1:0] p, input bit typed,
			input int unsigned n, input logic [IDX_W-1:0] zero_idx);
		dir_row_t r;
		r.is_cfg = 1'b0;
		r.reg_sel = REG_FRAME_WIDTH;
		r.reg_val = '0;
		r.pix = p;
		r.typed = typed;
		r.n = n;
		r.zero_idx = zero_idx;
		return r;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r < 15) return $urandom_range(1, 3);
		if (r < 19) return $urandom_range(4, 8);
		return $urandom_range(15, 40);
	endfunction

	function automatic int unsigned pick_gap(input bit steady);
		if (steady || $urandom_range(0, 2) != 0) return 0;
		return idle_len();
	endfunction

	// track register writes, predict on each input transfer, check each output transfer
	always @(posedge clk) begin : scoreboard
		int unsigned n;
		blur_result_t res_a, res_b, want;
		if (arst_n) begin
			if (cfg_we) begin
				if (cfg_index == REG_FRAME_WIDTH) width_reg = cfg_data;
				else height_reg = cfg_data;
			end
			if (in_valid && in_ready) begin
				apply_blur(old_pixel, n, res_a, res_b);
				if (cur_row.typed) begin
					n = cur_row.n;
					res_a = '{idx: cur_row.zero_idx, val: '0, done: 1'b0};
				end
				if (n > 0) blur_results_due.push_back(res_a);
				if (n > 1) blur_results_due.push_back(res_b);
			end
			if (out_valid && out_ready) begin
				if (blur_results_due.size() == 0) begin
					$error("unexpected result: pixel_index %0d new_pixel %0d frame_done %0d",
						pixel_index, new_pixel, frame_done);
					mismatches++;
				end else begin
					want = blur_results_due.pop_front();
					if (pixel_index !== want.idx) begin
						$error("pixel_index: expected %0d, actual %0d", want.idx, pixel_index);
						mismatches++;
					end
					if (new_pixel !== want.val) begin
						$error("new_pixel: expected %0d, actual %0d", want.val, new_pixel);
						mismatches++;
					end
					if (frame_done !== want.done) begin
						$error("frame_done: expected %0d, actual %0d", want.done, frame_done);
						mismatches++;
					end
				end
			end
		end
	end

	// receiver: random stalls, steady stretches, and a long hold-off on request
	initial begin : receiver
		int unsigned cnt;
		bit steady;
		out_ready = 1'b0;
		steady = 1'b0;
		cnt = 0;
		forever begin
			@(negedge clk);
			cnt++;
			if (cnt % 64 == 0) steady = ($urandom_range(0, 3) == 0);
			if (hold_request) begin
				hold_request = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end else if (steady || $urandom_range(0, 3) != 0) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b0;
				repeat (idle_len()) @(negedge clk);
			end
		end
	end

	// offer one item after an optional gap and hold it until the transfer
	task automatic offer(input dir_row_t row, input int unsigned gap);
		if (gap != 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		old_pixel <= row.pix;
		cur_row <= row;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_random(input bit steady);
		logic [PIX_W-1:0] pix;
		case ($urandom_range(0, 9))
			0: pix = '0;
			1: pix = '1;
			default: pix = PIX_W'($urandom_range(0, 255));
		endcase
		offer(px_row(pix, 1'b0, 0, '0), pick_gap(steady));
		rand_items++;
		if (rand_items == 100) hold_request = 1'b1;
	endtask

	// drop valid and wait for the block to drain before touching registers
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (blur_results_due.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t sel, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		int unsigned w_val, h_val, w_eff, h_eff, k, total2, i;
		bit steady, broken;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_FRAME_WIDTH;
		cfg_data = '0;
		in_valid = 1'b0;
		old_pixel = '0;
		cur_row = px_row('0, 1'b0, 0, '0);
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// columns: pixel, typed, result count, zero index
		directed_rows = '{
			// reset geometry: first row releases nothing
			px_row(8'hFF, 1'b1, 0, 0), px_row(8'h00, 1'b1, 0, 0),
			px_row(8'hAA, 1'b1, 0, 0), px_row(8'h55, 1'b1, 0, 0),
			px_row(8'h01, 1'b1, 0, 0), px_row(8'h80, 1'b1, 0, 0),
			// below-range values clamp to 2x3, position wraps to zero
			cfg_row(REG_FRAME_HEIGHT, 10'd0), cfg_row(REG_FRAME_WIDTH, 10'd0),
			px_row(8'hFF, 1'b1, 0, 0), px_row(8'hFF, 1'b1, 0, 0),
			px_row(8'hFF, 1'b1, 1, 0), px_row(8'h00, 1'b1, 1, 1),
			px_row(8'hFF, 1'b0, 0, 0), px_row(8'h00, 1'b0, 0, 0),
			// height to its maximum mid-frame, position kept
			px_row(8'h55, 1'b1, 0, 0), px_row(8'hAA, 1'b1, 0, 0),
			px_row(8'hFF, 1'b1, 1, 0), px_row(8'h01, 1'b1, 1, 1),
			cfg_row(REG_FRAME_HEIGHT, 10'h3FF),
			px_row(8'hFF, 1'b0, 0, 0), px_row(8'h00, 1'b0, 0, 0),
			px_row(8'h80, 1'b0, 0, 0),
			// shrink mid-frame past the position: restart at zero
			cfg_row(REG_FRAME_HEIGHT, 10'd3),
			px_row(8'h7F, 1'b1, 0, 0), px_row(8'hFE, 1'b1, 0, 0),
			px_row(8'hFF, 1'b1, 1, 0), px_row(8'h00, 1'b1, 1, 1),
			px_row(8'hFF, 1'b0, 0, 0), px_row(8'hFF, 1'b0, 0, 0)
		};
		foreach (directed_rows[j]) begin
			if (directed_rows[j].is_cfg) begin
				settle();
				write_reg(directed_rows[j].reg_sel, directed_rows[j].reg_val);
			end else begin
				offer(directed_rows[j], pick_gap(1'b0));
			end
		end

		// random phases: whole frames from position zero, some cut by a height change
		while (rand_items < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: w_val = $urandom_range(2, 8);
				6, 7: w_val = $urandom_range(0, 1);
				default: w_val = $urandom_range(9, 40);
			endcase
			h_val = $urandom_range(0, 6);
			w_eff = clamp_dim(CFG_W'(w_val), 2);
			h_eff = clamp_dim(CFG_W'(h_val), 3);
			steady = ($urandom_range(0, 3) == 0);
			broken = ($urandom_range(0, 4) == 0);
			settle();
			write_reg(REG_FRAME_WIDTH, CFG_W'(w_val));
			write_reg(REG_FRAME_HEIGHT, CFG_W'(h_val));
			if (broken) begin
				k = $urandom_range(1, w_eff * h_eff - 1);
				repeat (k) send_random(steady);
				h_val = $urandom_range(0, 8);
				total2 = w_eff * clamp_dim(CFG_W'(h_val), 3);
				settle();
				write_reg(REG_FRAME_HEIGHT, CFG_W'(h_val));
				// finish the frame; after a wrap run a whole new one
				if (k >= total2) repeat (total2) send_random(steady);
				else repeat (total2 - k) send_random(steady);
			end else begin
				repeat ($urandom_range(1, 2) * w_eff * h_eff) send_random(steady);
			end
		end

		// widest rows: first row and the start of the second, with a long output hold-off
		// once results flow
		settle();
		write_reg(REG_FRAME_WIDTH, 10'h3FF);
		write_reg(REG_FRAME_HEIGHT, 10'd3);
		for (i = 0; i < MAX_DIM + 48; i++) begin
			send_random(1'b0);
			if (i == MAX_DIM + 8) hold_request = 1'b1;
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (blur_results_due.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin : watchdog
		#8000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/ipfnb_pkg.sv
rtl/in_place_four_neighbour_blur_core.sv
tb/tb_in_place_four_neighbour_blur_core.sv
